/* src/kmds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared constants for the key matrix debounce scanner: counter limits,
// configuration defaults and register map.
// ----------------------------------------------------------------------------
package kmds_pkg;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] COUNT_MAX    = 4'd15;
   localparam logic [CNT_W-1:0] SETTLE_RESET = 4'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_SETTLE_COUNT = 1'b0;

endpackage

/* src/kmds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_if
// Valid/ready channels of the scanner: row samples in, key events out.
// ----------------------------------------------------------------------------
interface kmds_req_if #(
   parameter int RW = 2,
   parameter int CW = 2
) ();
   logic          valid;
   logic          ready;
   logic [RW-1:0] row;
   logic [CW-1:0] cols_raw;

   modport source (output valid, output row, output cols_raw, input ready);
   modport sink   (input valid, input row, input cols_raw, output ready);
endinterface

interface kmds_rsp_if #(
   parameter int KW = 3
) ();
   logic          valid;
   logic          ready;
   logic [KW-1:0] key_id;
   logic          pressed;
   logic          last;

   modport source (output valid, output key_id, output pressed, output last, input ready);
   modport sink   (input valid, input key_id, input pressed, input last, output ready);
endinterface

/* src/key_matrix_debounce_scanner_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_core
// Debounces a scanned key matrix and reports key press and release events.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one row sample per word: the driven row and its active-low
//   column lines. A sample with a row index of ROWS or more is dropped.
//   rsp_bus carries key events: key_id = row*COLS + column, pressed, and last
//   on the final event of a sample. A sample gives zero to COLS events.
//   The APB port holds settle_count at byte address 0 (reset value 5).
// Timing:
//   The front end updates the row state in the cycle a sample is taken, so
//   samples are accepted one per cycle while the queue has room. The first
//   event of a sample passes the queue, the expansion registers and the
//   output register; with rsp_bus.ready high, events follow one per cycle,
//   so a burst of changes throttles req_bus once the two-word queue fills.
// Reset:
//   All rows clear to released with zero counts; queue and outputs empty.
// Stall:
//   While rsp_bus.ready is low the output holds; once the queue is full,
//   req_bus.ready drops and every sample waits for queue space.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner_core #(
   parameter int ROWS = 3,
   parameter int COLS = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   kmds_req_if.sink                          req_bus,
   kmds_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kmds_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [kmds_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [kmds_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EW = RW + 2 * COLS;
   localparam int QDEPTH = 2;

   logic [kmds_pkg::CNT_W-1:0] settle_count_ff;
   logic [kmds_pkg::CNT_W-1:0] settle_count_in;
   logic                       reg_hit;

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   logic [EW-1:0] q_wdata;
   logic [EW-1:0] q_rdata;

   assign csr_pready = 1'b1;
   assign reg_hit    = csr_paddr[2] == kmds_pkg::REG_SETTLE_COUNT;

   always_comb begin
      settle_count_in = settle_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         settle_count_in = csr_pwdata[kmds_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_count_ff <= kmds_pkg::SETTLE_RESET;
      end else begin
         settle_count_ff <= settle_count_in;
      end
   end

   assign csr_prdata = reg_hit ? kmds_pkg::CSR_DATA_W'(settle_count_ff) : '0;

   kmds_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .settle_count (settle_count_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   kmds_queue #(
      .WIDTH (EW),
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   kmds_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_rdata),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* src/kmds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_front
// Takes row samples, updates the per-row debounce state and queues a word
// with the keys of that row that changed.
// ----------------------------------------------------------------------------
module kmds_front #(
   parameter int ROWS = 3,
   parameter int COLS = 2,
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int EW = RW + 2 * COLS
) (
   input  logic                         clock,
   input  logic                         reset,
   kmds_req_if.sink                     req_bus,
   input  logic [kmds_pkg::CNT_W-1:0]   settle_count,
   input  logic                         q_full,
   output logic                         q_push,
   output logic [EW-1:0]                q_data
);

   logic [COLS-1:0]            prev_ff [ROWS];
   logic [kmds_pkg::CNT_W-1:0] cnt_ff  [ROWS];
   logic [COLS-1:0]            deb_ff  [ROWS];
   logic [COLS-1:0]            rep_ff  [ROWS];

   logic                       accept;
   logic                       row_ok;
   logic                       same;
   logic [COLS-1:0]            sample;
   logic [kmds_pkg::CNT_W-1:0] cnt_in;
   logic [COLS-1:0]            deb_in;
   logic [COLS-1:0]            diff;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign row_ok        = int'(req_bus.row) < ROWS;
   assign sample        = req_bus.cols_raw;
   assign same          = prev_ff[req_bus.row] == sample;

   always_comb begin
      cnt_in = cnt_ff[req_bus.row];
      deb_in = deb_ff[req_bus.row];
      if (same) begin
         if (cnt_in != kmds_pkg::COUNT_MAX) begin
            cnt_in = cnt_in + 1'b1;
         end
         if (cnt_in == settle_count) begin
            deb_in = ~sample;
         end
      end else begin
         cnt_in = '0;
      end
   end

   assign diff   = deb_in ^ rep_ff[req_bus.row];
   assign q_push = accept && row_ok && (diff != '0);
   assign q_data = {req_bus.row, diff, deb_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            prev_ff[r] <= '0;
            cnt_ff[r]  <= '0;
            deb_ff[r]  <= '0;
            rep_ff[r]  <= '0;
         end
      end else if (accept && row_ok) begin
         prev_ff[req_bus.row] <= sample;
         cnt_ff[req_bus.row]  <= cnt_in;
         deb_ff[req_bus.row]  <= deb_in;
         // events are queued now, so the reported state catches up at once
         rep_ff[req_bus.row]  <= deb_in;
      end
   end

endmodule

/* src/kmds_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_queue
// Small register FIFO between the sample front end and the event back end.
// ----------------------------------------------------------------------------
module kmds_queue #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign full     = count_ff == NW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");
`endif

endmodule

/* src/kmds_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_back
// Expands each queued word into one key event per changed column, lowest
// column first, through a registered output stage.
// ----------------------------------------------------------------------------
module kmds_back #(
   parameter int ROWS = 3,
   parameter int COLS = 2,
   localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1,
   localparam int KW  = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1,
   localparam int EW  = RW + 2 * COLS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [EW-1:0] q_data,
   input  logic          q_empty,
   output logic          q_pop,
   kmds_rsp_if.source    rsp_bus
);

   logic            busy_ff;
   logic [RW-1:0]   row_ff;
   logic [COLS-1:0] mask_ff;
   logic [COLS-1:0] deb_ff;
   logic            out_valid_ff;
   logic [KW-1:0]   key_ff;
   logic            pressed_ff;
   logic            last_ff;

   logic [CIW-1:0]  col;
   logic [COLS-1:0] rest_mask;
   logic            emit_last;
   logic            out_free;
   logic            emit;
   logic [KW-1:0]   key_in;

   // lowest pending column
   always_comb begin
      col = '0;
      for (int c = COLS - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            col = CIW'(c);
         end
      end
      rest_mask      = mask_ff;
      rest_mask[col] = 1'b0;
   end

   assign emit_last = rest_mask == '0;
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign emit      = busy_ff && out_free;
   assign q_pop     = !q_empty && (!busy_ff || (emit && emit_last));
   assign key_in    = KW'(int'(row_ff) * COLS + int'(col));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            busy_ff <= 1'b1;
         end else if (emit && emit_last) begin
            busy_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         row_ff  <= q_data[EW-1 -: RW];
         mask_ff <= q_data[2*COLS-1:COLS];
         deb_ff  <= q_data[COLS-1:0];
      end else if (emit) begin
         mask_ff <= rest_mask;
      end
      if (emit) begin
         key_ff     <= key_in;
         pressed_ff <= deb_ff[col];
         last_ff    <= emit_last;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.key_id  = key_ff;
   assign rsp_bus.pressed = pressed_ff;
   assign rsp_bus.last    = last_ff;

`ifndef NO_ASSERTIONS
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> mask_ff != '0)
      else $error("busy with no pending column");

   a_more_after_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !last_ff |-> busy_ff)
      else $error("event without last flag but nothing left to send");
`endif

endmodule

/* tb/kmds_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmds_event_checker
// Watches the sample and event channels of the key matrix debounce scanner.
// It keeps its own per-row debounce state and settle setting, predicts the
// key events of every accepted sample, and compares each event word taken
// from the block with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module kmds_event_checker #(
   parameter int ROWS = 3,
   parameter int COLS = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   kmds_req_if                           req_mon,
   kmds_rsp_if                           rsp_mon,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [kmds_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [kmds_pkg::CSR_DATA_W-1:0] pwdata,
   output int                            fail_count,
   output int                            events_pending,
   output int                            samples_taken,
   output int                            events_checked
);

   typedef struct packed {
      logic [2:0] key_id;
      logic       pressed;
      logic       last;
   } key_event_type;

   key_event_type              expected_events[$];
   logic [COLS-1:0]            row_sample     [ROWS];
   logic [kmds_pkg::CNT_W-1:0] run_count      [ROWS];
   logic [COLS-1:0]            settled_keys   [ROWS];
   logic [COLS-1:0]            announced_keys [ROWS];
   logic [kmds_pkg::CNT_W-1:0] settle_target;
   key_event_type              got_event;
   key_event_type              want_event;
   int                         mismatches;
   int                         taken;
   int                         checked;

   task automatic report_mismatch(input string what, input key_event_type got,
                                  input key_event_type want);
      $display("[%0t] key event mismatch (%s): got id=%0d pressed=%0b last=%0b, %s%0d %s%0b %s%0b",
               $time, what, got.key_id, got.pressed, got.last,
               "want id=", want.key_id, "pressed=", want.pressed,
               "last=", want.last);
      mismatches++;
   endtask

   // Debounce one row sample and queue the key events it causes.
   task automatic scan_row(input logic [1:0] r, input logic [COLS-1:0] cols);
      logic [COLS-1:0] changed;
      key_event_type   ev;
      int              n;
      n = 0;
      // drop samples of rows that do not exist
      if (r >= ROWS) return;
      if (row_sample[r] == cols) begin
         if (run_count[r] != kmds_pkg::COUNT_MAX) run_count[r]++;
         if (run_count[r] == settle_target) settled_keys[r] = ~cols;
      end else begin
         run_count[r]  = '0;
         row_sample[r] = cols;
      end
      changed = settled_keys[r] ^ announced_keys[r];
      for (int c = 0; c < COLS; c++) begin
         if (changed[c]) begin
            ev.key_id  = 3'(r * COLS + c);
            ev.pressed = settled_keys[r][c];
            ev.last    = 1'b0;
            expected_events.push_back(ev);
            announced_keys[r][c] = settled_keys[r][c];
            n++;
         end
      end
      if (n > 0) expected_events[expected_events.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            row_sample[r]     = '0;
            run_count[r]      = '0;
            settled_keys[r]   = '0;
            announced_keys[r] = '0;
         end
         settle_target = kmds_pkg::SETTLE_RESET;
         expected_events.delete();
      end else begin
         // check outgoing events before queueing new ones
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_event = '{key_id: rsp_mon.key_id, pressed: rsp_mon.pressed,
                          last: rsp_mon.last};
            if (expected_events.size() == 0) begin
               report_mismatch("no event expected", got_event, '0);
            end else begin
               want_event = expected_events.pop_front();
               checked++;
               if (got_event !== want_event)
                  report_mismatch("wrong field", got_event, want_event);
            end
         end
         if (psel && penable && pwrite && pready &&
             paddr[2] == kmds_pkg::REG_SETTLE_COUNT)
            settle_target = pwdata[kmds_pkg::CNT_W-1:0];
         if (req_mon.valid && req_mon.ready) begin
            taken++;
            scan_row(req_mon.row, req_mon.cols_raw);
         end
      end
      fail_count     <= mismatches;
      events_pending <= expected_events.size();
      samples_taken  <= taken;
      events_checked <= checked;
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the key matrix debounce scanner. A short directed
// run presses keys on every row and releases those of row 2 at the reset
// settle count, then random runs of mostly stable row samples with glitches
// and stray rows go through several settle counts, the extremes among them,
// with random sample gaps and event stalls except in the quiet runs.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ROWS          = 3;
   localparam int COLS          = 2;
   localparam int PHASE_SAMPLES = 165;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [kmds_pkg::CSR_ADDR_W-1:0] SETTLE_ADDR =
      {kmds_pkg::REG_SETTLE_COUNT, 2'b00};
   // first address past the register map
   localparam logic [kmds_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      {~kmds_pkg::REG_SETTLE_COUNT, 2'b00};

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [kmds_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [kmds_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [kmds_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int  fail_count;
   int  events_pending;
   int  samples_taken;
   int  events_checked;
   int  cycles;
   int  ready_hold;
   int  settings_run;
   bit  idling_on;
   logic [COLS-1:0] row_target [ROWS];

   kmds_req_if #(.RW(2), .CW(COLS)) req_bus ();
   kmds_rsp_if #(.KW(3))            rsp_bus ();

   key_matrix_debounce_scanner_core #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   kmds_event_checker #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) event_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .pready         (csr_pready),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .fail_count     (fail_count),
      .events_pending (events_pending),
      .samples_taken  (samples_taken),
      .events_checked (events_checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles, %0d events still pending",
                  cycles, events_pending);
         $display("tb: failure");
         $finish;
      end
   end

   // Event side: random stall and run bursts while idling is on.
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold    <= $urandom_range(0, 10);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold    <= $urandom_range(0, 15);
      end
   end

   task automatic push_sample(input logic [1:0] r, input logic [COLS-1:0] c);
      req_bus.valid    <= 1'b1;
      req_bus.row      <= r;
      req_bus.cols_raw <= c;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic hold_off(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic repeat_sample(input logic [1:0] r, input logic [COLS-1:0] c,
                                input int n);
      repeat (n) push_sample(r, c);
   endtask

   task automatic csr_write(input logic [kmds_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [kmds_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending samples and wait until all predicted events have drained.
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input logic [kmds_pkg::CNT_W-1:0] settle,
                               input bit quiet, input int count);
      logic [kmds_pkg::CSR_DATA_W-1:0] data;
      logic [1:0]                      r;
      logic [COLS-1:0]                 c;
      int                              change_div;
      int                              glitch_div;
      wait_quiet();
      data                      = $urandom();
      data[kmds_pkg::CNT_W-1:0] = settle;
      csr_write(SETTLE_ADDR, data);
      idling_on <= !quiet;
      settings_run++;
      // keep rows stable long enough to settle even at the largest count
      change_div = 2 * settle + 4;
      glitch_div = 2 * settle + 6;
      repeat (count) begin
         if (!quiet && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
         r = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, ROWS - 1));
         if (r < ROWS) begin
            if ($urandom_range(1, change_div) == 1)
               row_target[r] = COLS'($urandom_range(0, 3));
            c = ($urandom_range(1, glitch_div) == 1) ? COLS'($urandom_range(0, 3))
                                                     : row_target[r];
         end else begin
            c = COLS'($urandom_range(0, 3));
         end
         push_sample(r, c);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.row      <= '0;
      req_bus.cols_raw <= '0;
      foreach (row_target[i]) row_target[i] = COLS'($urandom_range(0, 3));
      repeat (3) @(posedge clock);
      reset     <= 1'b0;
      idling_on <= 1'b1;

      // a write past the map must leave the reset settle count in place
      csr_write(UNMAPPED_ADDR, 32'hFFFF_FFF1);
      settings_run = 1;
      repeat_sample(2'd3, 2'b00, 1);
      repeat_sample(2'd3, 2'b11, 1);
      repeat_sample(2'd2, 2'b00, 6);
      repeat_sample(2'd0, 2'b10, 6);
      repeat_sample(2'd1, 2'b01, 6);
      repeat_sample(2'd2, 2'b11, 6);

      random_phase(4'd1, 1'b0, PHASE_SAMPLES);
      random_phase(4'd15, 1'b0, PHASE_SAMPLES);
      random_phase(4'd0, 1'b1, PHASE_SAMPLES);
      random_phase(4'd14, 1'b0, PHASE_SAMPLES);
      repeat (3) random_phase(kmds_pkg::CNT_W'($urandom_range(1, 14)), 1'b0,
                              PHASE_SAMPLES);
      random_phase(kmds_pkg::SETTLE_RESET, 1'b1, PHASE_SAMPLES);
      wait_quiet();

      $display("covered %0d row samples and %0d key events over %0d settle counts",
               samples_taken, events_checked, settings_run);
      $display("settle counts 0, 1, 14 and 15 included, with stray rows and glitches");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* key_matrix_debounce_scanner_core.f */
src/kmds_pkg.sv
src/kmds_if.sv
src/kmds_front.sv
src/kmds_queue.sv
src/kmds_back.sv
src/key_matrix_debounce_scanner_core.sv
tb/kmds_event_checker.sv
tb/tb_top.sv
